### design/b64d_pkg.sv
// Shared types, constants and the character classifier for the base64 stream decoder.
package b64d_pkg;

   // Depth of the record queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   // Characters of note
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_SLASH   = 8'h2f;

   // Sextet offsets of the alphabet ranges
   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   // One decoded group handed from front to back: up to three bytes, MSB first
   typedef struct packed {
      logic [23:0] data;
      logic [1:0]  nbytes;     // words to emit, 1..3
      logic        has_data;   // 0 for a bare end marker
      logic        frame_end;  // last word of this record ends the frame
   } rec_type;

   // Classified character: stop flag and sextet value
   typedef struct packed {
      logic       stop;
      logic [5:0] sextet;
   } sextet_type;

   function automatic sextet_type char_to_sextet(input logic [7:0] c);
      sextet_type r;
      logic [7:0] diff;
      r.stop = 1'b0;
      r.sextet = '0;
      diff = '0;
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         diff = c - CHAR_UPPER_A;
         r.sextet = diff[5:0];
      end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         diff = c - CHAR_LOWER_A;
         r.sextet = diff[5:0] + SEXTET_LOWER_BASE;
      end else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
         diff = c - CHAR_DIGIT_0;
         r.sextet = diff[5:0] + SEXTET_DIGIT_BASE;
      end else if (c == CHAR_PLUS) begin
         r.sextet = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         r.sextet = SEXTET_SLASH;
      end else begin
         r.stop = 1'b1;
      end
      return r;
   endfunction

endpackage

### design/b64d_front.sv
// Front end: classifies characters, gathers sextets and builds byte-group records.
module b64d_front
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_char,
   input  logic       last_char,
   output logic       rec_push,
   output rec_type    rec
);

   logic [5:0] hold_ff [3];
   logic [5:0] hold_in [3];
   logic [1:0] count_ff, count_in;
   logic       stopped_ff, stopped_in;

   sextet_type cls;
   logic       skip;
   logic       complete;
   logic [1:0] count_upd;

   // Classify and update the partial group
   always_comb begin
      cls = char_to_sextet(in_char);
      skip = stopped_ff | cls.stop;
      complete = !skip && (count_ff == 2'd3);
      hold_in = hold_ff;
      count_upd = count_ff;
      stopped_in = stopped_ff | cls.stop;
      if (!skip && count_ff != 2'd3) begin
         hold_in[count_ff] = cls.sextet;
         count_upd = count_ff + 2'd1;
      end
      if (complete) begin
         count_upd = 2'd0;
      end
      count_in = count_upd;
      if (last_char) begin
         count_in = 2'd0;
         stopped_in = 1'b0;
      end
   end

   // Record for a completed group or a frame flush
   always_comb begin
      rec.frame_end = last_char;
      rec.has_data = 1'b1;
      rec.nbytes = 2'd3;
      rec.data = {hold_ff[0], hold_ff[1], hold_ff[2], cls.sextet};
      if (!complete) begin
         rec.data = {hold_in[0], hold_in[1], hold_in[2], 6'd0};
         if (count_upd[1]) begin
            rec.nbytes = count_upd - 2'd1;
         end else begin
            rec.nbytes = 2'd1;
            rec.has_data = 1'b0;
            rec.data = '0;
         end
      end
      rec_push = accept && (complete || last_char);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

endmodule

### design/b64d_queue.sv
// Short record queue between front and back.
module b64d_queue
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output rec_type head_rec
);

   rec_type                  slot_ff [QueueDepth];
   logic [QueuePtrBits-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntBits-1:0]  count_ff;
   logic                     do_push, do_pop;

   assign full = (count_ff == QueueCntBits'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_rec = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

### design/b64d_back.sv
// Back end: unpacks records into one output word per cycle while the consumer pops.
module b64d_back
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  rec_type    head_rec,
   output logic       head_pop,
   input  logic       pop,
   output logic       empty,
   output logic [7:0] data_byte,
   output logic       byte_valid,
   output logic       frame_end
);

   rec_type    cur_ff, cur_in;
   logic [1:0] left_ff, left_in;
   logic       busy_ff, busy_in;
   logic       take;
   logic       reload;

   // Shift out the current record, pull the next one when it is used up
   always_comb begin
      take = busy_ff && pop;
      reload = !busy_ff || (take && left_ff == 2'd1);
      head_pop = reload && head_valid;
      cur_in = cur_ff;
      left_in = left_ff;
      busy_in = busy_ff;
      if (reload) begin
         busy_in = head_valid;
         cur_in = head_rec;
         left_in = head_rec.nbytes;
      end else if (take) begin
         cur_in.data = {cur_ff.data[15:0], 8'd0};
         left_in = left_ff - 2'd1;
      end
   end

   assign empty = !busy_ff;
   assign data_byte = cur_ff.data[23:16];
   assign byte_valid = cur_ff.has_data;
   assign frame_end = cur_ff.frame_end && (left_ff == 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         left_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

### design/base64_stream_decoder.sv
// Top level of the base64 stream decoder.
// Takes one base64 character per cycle (req_push while req_full is low) and
// delivers decoded bytes one word per cycle on a queue-style output
// (rsp_empty/rsp_pop). Every character is classified by the front end as it
// is accepted; complete groups and frame flushes become records in a
// four-entry queue, and the back end emits one byte word per cycle from
// them, so a steady stream of one character per cycle is sustained as long
// as the consumer pops. req_full rises only when four records wait behind
// the one being emitted, which happens when the consumer falls behind. The
// first '=' or non-alphabet character ends decoding for the rest of the
// frame; the final word of every frame has rsp_frame_end set, as a bare
// marker with rsp_byte_valid low when no byte is left. The first word of a
// record goes through the queue and then the output register before it is
// on the result ports.
module base64_stream_decoder
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_char,
   input  logic       req_last_char,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_frame_end
);

   logic    accept;
   logic    rec_push;
   rec_type rec;
   logic    head_valid;
   rec_type head_rec;
   logic    head_pop;

   assign accept = req_push && !req_full;

   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_char   (req_in_char),
      .last_char (req_last_char),
      .rec_push  (rec_push),
      .rec       (rec)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (rec_push),
      .push_rec   (rec),
      .pop        (head_pop),
      .full       (req_full),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .head_pop   (head_pop),
      .pop        (rsp_pop),
      .empty      (rsp_empty),
      .data_byte  (rsp_data_byte),
      .byte_valid (rsp_byte_valid),
      .frame_end  (rsp_frame_end)
   );

endmodule
